### rtl/core/wspr_pkg.sv
`timescale 1ns / 1ps

package wspr_pkg;

    // Frame geometry and convolutional code taps.
    localparam int NSYM       = 162;
    localparam int MSG_BITS   = 50;
    localparam int CALL_BITS  = 28;
    localparam int GRID_BITS  = 22;
    localparam logic [31:0] TAP_A = 32'hF2D05351;
    localparam logic [31:0] TAP_B = 32'hE4613C47;

    // Packing constants.
    localparam int CALL_MUL_1    = 36;
    localparam int CALL_MUL_2    = 10;
    localparam int CALL_MUL_TAIL = 27;
    localparam int TAIL_BLANK    = 26;
    localparam int LON_BASE      = 179;
    localparam int LAT_SPAN      = 180;
    localparam int GRID_DIGITS   = 10;
    localparam int PWR_SCALE     = 128;
    localparam int PWR_OFFSET    = 64;

    // Character codes: 0..9 digits, 10..35 letters.
    localparam logic [5:0] CODE_BLANK     = 6'd36;
    localparam logic [5:0] CODE_BAD       = 6'd63;
    localparam logic [5:0] CODE_LAST_DIG  = 6'd9;
    localparam logic [5:0] CODE_LAST_CHAR = 6'd35;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CALL  = 2'd1;
    localparam logic [1:0] STATUS_BAD_GRID  = 2'd2;
    localparam logic [1:0] STATUS_BAD_POWER = 2'd3;

    // Sync vector, element 0 is the leftmost bit.
    localparam logic [0:NSYM-1] SYNC_VEC = {
        30'b110000001000111000100101111000,
        30'b000010010100000010110011010001,
        30'b101000011010101010010010110001,
        30'b101010001000001001001110110011,
        30'b010001110000010100110000000110,
        12'b101100011000
    };

    typedef struct packed {
        logic [7:0] call_char_0;
        logic [7:0] call_char_1;
        logic [7:0] call_char_2;
        logic [7:0] call_char_3;
        logic [7:0] call_char_4;
        logic [7:0] call_char_5;
        logic [2:0] call_length;
        logic [7:0] grid_lon_letter;
        logic [7:0] grid_lat_letter;
        logic [7:0] grid_lon_digit;
        logic [7:0] grid_lat_digit;
        logic [5:0] power_level;
    } in_word_t;

    typedef struct packed {
        logic [1:0] sym_0;
        logic [1:0] sym_1;
        logic [1:0] sym_2;
        logic [1:0] sym_3;
        logic [1:0] sym_4;
        logic [1:0] sym_5;
        logic [1:0] sym_6;
        logic [1:0] sym_7;
        logic [4:0] group_index;
        logic [3:0] valid_count;
        logic [1:0] status;
        logic       last_of_run;
    } out_word_t;

    // Handoff from the packer to the encoder sequencer.
    typedef struct packed {
        logic                done;
        logic [1:0]          status;
        logic [MSG_BITS-1:0] msg;
    } pack_res_t;

    typedef enum logic [1:0] {
        PK_IDLE,
        PK_CHECK,
        PK_RUN
    } pk_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACK,
        ST_ENCODE,
        ST_READ,
        ST_DRAIN,
        ST_SEND,
        ST_ERROR
    } top_state_t;

    function automatic logic [5:0] char_code(input logic [7:0] c);
        logic [5:0] code;
        if (c >= 8'h30 && c <= 8'h39) begin
            code = 6'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            code = 6'(c - 8'h41) + 6'd10;
        end else begin
            code = CODE_BAD;
        end
        return code;
    endfunction

    function automatic logic power_ok(input logic [5:0] pw);
        logic ok;
        case (pw)
            6'd0, 6'd3, 6'd7, 6'd10, 6'd13, 6'd17,
            6'd20, 6'd23, 6'd27, 6'd30, 6'd33, 6'd37: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [7:0] bitrev8(input logic [7:0] k);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[7-b] = k[b];
        end
        return r;
    endfunction

endpackage

### rtl/core/wspr_pack.sv
`timescale 1ns / 1ps

// Validates one message and packs it into the 50-bit source word,
// one multiply-accumulate step per cycle.
module wspr_pack (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  wspr_pkg::in_word_t  msg_in,
    output wspr_pkg::pack_res_t result
);
    import wspr_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'd5;

    pk_state_t state_reg, state_next;

    in_word_t               in_reg;
    logic [5:0]             val_reg [6];
    logic [5:0]             val_next [6];
    logic [2:0]             step_reg, step_next;
    logic                   done_reg, done_next;
    logic [1:0]             status_reg, status_next;
    logic [CALL_BITS-1:0]   n_reg, n_next;
    logic [GRID_BITS-1:0]   m_reg, m_next;

    // Control decoded from the state.
    logic capture_en, check_en, run_en;

    // Check stage signals.
    logic [7:0] chars [6];
    logic [5:0] raw [6];
    logic [5:0] pos [6];
    logic       raw_bad, off, call_bad, grid_bad;
    logic [3:0] aligned_len;
    logic [1:0] chk_status;

    // Grid digits taken from the held message.
    logic [4:0] lon_l, lat_l;
    logic [3:0] lon_d, lat_d;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            PK_IDLE:  if (start) state_next = PK_CHECK;
            PK_CHECK: state_next = (chk_status != STATUS_OK) ? PK_IDLE : PK_RUN;
            PK_RUN:   if (step_reg == LAST_STEP) state_next = PK_IDLE;
            default:  state_next = PK_IDLE;
        endcase
    end

    always_comb begin
        capture_en = 1'b0;
        check_en   = 1'b0;
        run_en     = 1'b0;
        unique case (state_reg)
            PK_IDLE:  capture_en = start;
            PK_CHECK: check_en   = 1'b1;
            PK_RUN:   run_en     = 1'b1;
            default:  capture_en = 1'b0;
        endcase
    end

    // Callsign alignment and validation.
    always_comb begin
        chars[0] = in_reg.call_char_0;
        chars[1] = in_reg.call_char_1;
        chars[2] = in_reg.call_char_2;
        chars[3] = in_reg.call_char_3;
        chars[4] = in_reg.call_char_4;
        chars[5] = in_reg.call_char_5;
        raw_bad = 1'b0;
        for (int i = 0; i < 6; i++) begin
            raw[i] = (3'(i) >= in_reg.call_length) ? CODE_BLANK : char_code(chars[i]);
            if (raw[i] == CODE_BAD) raw_bad = 1'b1;
        end
        off = (raw[2] > CODE_LAST_DIG) && (raw[1] <= CODE_LAST_DIG);
        aligned_len = {1'b0, in_reg.call_length} + {3'b000, off};
        pos[0] = off ? CODE_BLANK : raw[0];
        for (int i = 1; i < 6; i++) begin
            pos[i] = off ? raw[i-1] : raw[i];
        end
        call_bad = (in_reg.call_length < 3'd3) || (in_reg.call_length > 3'd6) || raw_bad
                || (aligned_len > 4'd6) || (pos[1] > CODE_LAST_CHAR)
                || (pos[2] > CODE_LAST_DIG);
        for (int i = 3; i < 6; i++) begin
            if (pos[i] <= CODE_LAST_DIG) call_bad = 1'b1;
        end
        grid_bad = (in_reg.grid_lon_letter < 8'h41) || (in_reg.grid_lon_letter > 8'h52)
                || (in_reg.grid_lat_letter < 8'h41) || (in_reg.grid_lat_letter > 8'h52)
                || (in_reg.grid_lon_digit < 8'h30) || (in_reg.grid_lon_digit > 8'h39)
                || (in_reg.grid_lat_digit < 8'h30) || (in_reg.grid_lat_digit > 8'h39);
        priority if (call_bad) begin
            chk_status = STATUS_BAD_CALL;
        end else if (grid_bad) begin
            chk_status = STATUS_BAD_GRID;
        end else if (!power_ok(in_reg.power_level)) begin
            chk_status = STATUS_BAD_POWER;
        end else begin
            chk_status = STATUS_OK;
        end
    end

    assign lon_l = 5'(in_reg.grid_lon_letter - 8'h41);
    assign lat_l = 5'(in_reg.grid_lat_letter - 8'h41);
    assign lon_d = 4'(in_reg.grid_lon_digit - 8'h30);
    assign lat_d = 4'(in_reg.grid_lat_digit - 8'h30);

    always_comb begin
        val_next    = val_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        if (check_en) begin
            status_next = chk_status;
            done_next   = (chk_status != STATUS_OK);
            step_next   = '0;
            for (int i = 0; i < 3; i++) begin
                val_next[i] = pos[i];
            end
            for (int i = 3; i < 6; i++) begin
                val_next[i] = (pos[i] == CODE_BLANK) ? 6'(TAIL_BLANK) : pos[i] - 6'd10;
            end
        end
        if (run_en) begin
            step_next = step_reg + 3'd1;
            done_next = (step_reg == LAST_STEP);
            unique case (step_reg)
                3'd0: begin
                    n_next = CALL_BITS'(val_reg[0]);
                    m_next = GRID_BITS'(LON_BASE) - GRID_BITS'(lon_l) * GRID_BITS'(GRID_DIGITS)
                           - GRID_BITS'(lon_d);
                end
                3'd1: begin
                    n_next = n_reg * CALL_BITS'(CALL_MUL_1) + CALL_BITS'(val_reg[1]);
                    m_next = m_reg * GRID_BITS'(LAT_SPAN)
                           + GRID_BITS'(lat_l) * GRID_BITS'(GRID_DIGITS) + GRID_BITS'(lat_d);
                end
                3'd2: begin
                    n_next = n_reg * CALL_BITS'(CALL_MUL_2) + CALL_BITS'(val_reg[2]);
                    m_next = m_reg * GRID_BITS'(PWR_SCALE) + GRID_BITS'(in_reg.power_level)
                           + GRID_BITS'(PWR_OFFSET);
                end
                3'd3, 3'd4, 3'd5: begin
                    n_next = n_reg * CALL_BITS'(CALL_MUL_TAIL) + CALL_BITS'(val_reg[step_reg]);
                end
                default: n_next = n_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PK_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture_en) in_reg <= msg_in;
        val_reg    <= val_next;
        step_reg   <= step_next;
        status_reg <= status_next;
        n_reg      <= n_next;
        m_reg      <= m_next;
    end

    assign result.done   = done_reg;
    assign result.status = status_reg;
    assign result.msg    = {n_reg, m_reg};

endmodule

### rtl/core/wspr_message_symbol_encoder.sv
`timescale 1ns / 1ps
// A good message's first result word follows packing, a walk over all 256 bit-reversed
// interleaver addresses, the reads of the first group, a drain and the send state; a bad
// one gives its single error word once packing has failed. Each further group is read,
// drained and sent, and output stall holds it; at 8 per group the last group holds two
// symbols. The next message is taken after the last word of the run is accepted.
// Reset (aresetn, synchronous, active low) clears control state only, not the symbol memory.
module wspr_message_symbol_encoder #(
    parameter int SYMBOLS_PER_RESULT = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wspr_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wspr_pkg::out_word_t m_data
);
    import wspr_pkg::*;

    // Last slot index of a group and the address of the final symbol.
    localparam logic [2:0] LAST_SLOT = 3'(SYMBOLS_PER_RESULT - 1);
    localparam logic [7:0] LAST_ADDR = 8'(NSYM - 1);
    localparam logic [7:0] LAST_K    = 8'hFF;

    top_state_t state_reg, state_next;

    pack_res_t pack_res;
    logic      in_fire;

    // Control decoded from the state.
    logic enc_active, rd_issue, grp_start;

    // Encoder and interleaver.
    logic [MSG_BITS-1:0] msg_reg, msg_next;
    logic [31:0]         shift_reg, shift_next;
    logic [31:0]         shift_in;
    logic [7:0]          k_reg, k_next;
    logic                phase_reg, phase_next;
    logic [7:0]          wr_addr;
    logic                enc_we;
    logic                coded;

    // Symbol memory with a registered read port.
    logic [1:0] store_mem [NSYM];
    logic [1:0] rd_q_reg;

    // Group assembly.
    logic [7:0] addr_reg, addr_next;
    logic [2:0] slot_reg, slot_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [4:0] grp_reg, grp_next;
    logic       last_grp_reg, last_grp_next;
    logic       rd_valid_reg;
    logic [2:0] rd_slot_reg;
    logic [1:0] buf_reg [8];
    logic [1:0] buf_next [8];
    logic [1:0] err_status_reg, err_status_next;

    assign in_fire = s_valid && s_ready;

    // The packer validates the callsign, locator and power and builds the 50-bit word.
    wspr_pack u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_fire),
        .msg_in  (s_data),
        .result  (pack_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_PACK;
            ST_PACK: begin
                if (pack_res.done) begin
                    state_next = (pack_res.status != STATUS_OK) ? ST_ERROR : ST_ENCODE;
                end
            end
            ST_ENCODE: if (k_reg == LAST_K) state_next = ST_READ;
            ST_READ: begin
                if (slot_reg == LAST_SLOT || addr_reg == LAST_ADDR) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_SEND;
            ST_SEND: begin
                if (m_ready) state_next = last_grp_reg ? ST_IDLE : ST_READ;
            end
            ST_ERROR: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        enc_active = 1'b0;
        rd_issue   = 1'b0;
        grp_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_PACK:   s_ready = 1'b0;
            ST_ENCODE: begin
                enc_active = 1'b1;
                grp_start  = (k_reg == LAST_K);
            end
            ST_READ:   rd_issue = 1'b1;
            ST_DRAIN:  rd_issue = 1'b0;
            ST_SEND: begin
                m_valid   = 1'b1;
                grp_start = m_ready && !last_grp_reg;
            end
            ST_ERROR:  m_valid = 1'b1;
            default:   s_ready = 1'b0;
        endcase
    end

    // One bit-reversed address per cycle. Addresses inside the frame take the next coded
    // bit; even coded bits shift a new message bit into the encoder and use tap A, odd
    // ones reuse the same register contents with tap B.
    assign wr_addr  = bitrev8(k_reg);
    assign enc_we   = enc_active && (wr_addr < 8'(NSYM));
    assign shift_in = {shift_reg[30:0], msg_reg[MSG_BITS-1]};
    assign coded    = phase_reg ? ^(shift_reg & TAP_B) : ^(shift_in & TAP_A);

    always_comb begin
        msg_next        = msg_reg;
        shift_next      = shift_reg;
        k_next          = k_reg;
        phase_next      = phase_reg;
        err_status_next = err_status_reg;
        if (state_reg == ST_PACK && pack_res.done) begin
            err_status_next = pack_res.status;
            msg_next        = pack_res.msg;
            shift_next      = '0;
            k_next          = '0;
            phase_next      = 1'b0;
        end
        if (enc_active) begin
            k_next = k_reg + 8'd1;
        end
        if (enc_we) begin
            phase_next = !phase_reg;
            if (!phase_reg) begin
                shift_next = shift_in;
                msg_next   = {msg_reg[MSG_BITS-2:0], 1'b0};
            end
        end
    end

    // Groups are read one symbol per cycle; each read word is registered at the memory
    // and then written to its slot. Slots never read stay zero from the clear at group start.
    always_comb begin
        addr_next     = addr_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        grp_next      = grp_reg;
        last_grp_next = last_grp_reg;
        buf_next      = buf_reg;
        if (grp_start) begin
            slot_next     = '0;
            cnt_next      = '0;
            last_grp_next = 1'b0;
            for (int i = 0; i < 8; i++) begin
                buf_next[i] = '0;
            end
            if (state_reg == ST_ENCODE) begin
                addr_next = '0;
                grp_next  = '0;
            end else begin
                grp_next = grp_reg + 5'd1;
            end
        end
        if (rd_issue) begin
            addr_next = addr_reg + 8'd1;
            slot_next = slot_reg + 3'd1;
            cnt_next  = cnt_reg + 4'd1;
            if (addr_reg == LAST_ADDR) last_grp_next = 1'b1;
        end
        if (rd_valid_reg) begin
            buf_next[rd_slot_reg] = rd_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        msg_reg        <= msg_next;
        shift_reg      <= shift_next;
        k_reg          <= k_next;
        phase_reg      <= phase_next;
        err_status_reg <= err_status_next;
        addr_reg       <= addr_next;
        slot_reg       <= slot_next;
        cnt_reg        <= cnt_next;
        grp_reg        <= grp_next;
        last_grp_reg   <= last_grp_next;
        rd_slot_reg    <= slot_reg;
        buf_reg        <= buf_next;
    end

    // Symbol memory: each symbol is the sync bit plus twice the coded bit.
    always_ff @(posedge aclk) begin
        if (enc_we) store_mem[wr_addr] <= {coded, SYNC_VEC[wr_addr]};
        if (rd_issue) rd_q_reg <= store_mem[addr_reg];
    end

    // The result word comes straight from registers; an error word is all zero apart
    // from its status code and the last flag.
    always_comb begin
        if (state_reg == ST_ERROR) begin
            m_data             = '0;
            m_data.status      = err_status_reg;
            m_data.last_of_run = 1'b1;
        end else begin
            m_data.sym_0       = buf_reg[0];
            m_data.sym_1       = buf_reg[1];
            m_data.sym_2       = buf_reg[2];
            m_data.sym_3       = buf_reg[3];
            m_data.sym_4       = buf_reg[4];
            m_data.sym_5       = buf_reg[5];
            m_data.sym_6       = buf_reg[6];
            m_data.sym_7       = buf_reg[7];
            m_data.group_index = grp_reg;
            m_data.valid_count = cnt_reg;
            m_data.status      = STATUS_OK;
            m_data.last_of_run = last_grp_reg;
        end
    end

endmodule

### rtl/core/wspr_checker.sv
`timescale 1ns / 1ps

// Port-level checks for the message encoder.
module wspr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input wspr_pkg::out_word_t m_data
);
    import wspr_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A new message is never taken while a result is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // An error word is the only word of its message and carries no symbols.
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STATUS_OK) |->
            m_data.last_of_run && (m_data.valid_count == 4'd0))
        else $error("error word malformed");

    // Packing takes time: no result in the cycle after a message is taken.
    a_pack_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result right after input accept");

    // More groups follow a word that is not the last one.
    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_run |=> !s_ready)
        else $error("input ready in the middle of a run");

endmodule

bind wspr_message_symbol_encoder wspr_checker u_wspr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
